// File: design/art_pkg.sv
// Shared types and constants for the allocation range tracker.
// Used by art_ctrl, art_dp and the top level; depends on nothing.
package art_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int IDX_W      = 6;	// slot index width
	localparam int CNT_W      = 7;	// counts up to SLOT_COUNT
	localparam int TOT_W      = 71;	// 64-bit total plus carry count
	localparam int PADDR_W    = 3;

	localparam logic [CNT_W-1:0] SLOTS_RESET = 7'd64;
	localparam logic [0:0]       REG_SLOTS_IN_USE = 1'b0;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_RELEASE  = 3'd1,
		OP_FIND_REQ = 3'd2,
		OP_FIND_LEN = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] address;
		logic [63:0] length;
		logic [63:0] requested_length;
	} in_word_t;

	typedef struct packed {
		logic             success;
		logic [63:0]      base_address;
		logic [63:0]      length_out;
		logic [CNT_W-1:0] live_entries;
		logic [63:0]      live_bytes;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_OV_RD,
		ST_OV_CMP,
		ST_MOD,
		ST_FREE,
		ST_FD_RD,
		ST_FD_CMP,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_inc;
		logic rd;
		logic mod_init;
		logic mod_sub;
		logic free_init;
		logic free_step;
		logic do_insert;
		logic do_release;
		logic do_clear;
		logic set_hit;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       pre_ok;
		logic       addr_zero;
		logic       idx_end;
		logic       live_hit;
		logic       overlap;
		logic       match;
		logic       contains;
		logic       mod_ge;
		logic       free_hit;
		logic       fcnt_end;
		logic       out_free;
	} status_t;

endpackage

// File: design/art_ctrl.sv
// Sequencer for the allocation range tracker: one word at a time.
// Depends on art_pkg; drives commands into art_dp.
module art_ctrl
	import art_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_DISPATCH;
			ST_DISPATCH: begin
				case (st.opcode)
					OP_INSERT:   state_nxt = st.pre_ok ? ST_OV_RD : ST_RESULT;
					OP_RELEASE, OP_FIND_REQ, OP_FIND_LEN:
						state_nxt = st.addr_zero ? ST_RESULT : ST_FD_RD;
					default:     state_nxt = ST_RESULT;
				endcase
			end
			ST_OV_RD:  state_nxt = st.idx_end ? ST_MOD : ST_OV_CMP;
			ST_OV_CMP: state_nxt = (st.live_hit && st.overlap) ? ST_RESULT : ST_OV_RD;
			ST_MOD:    if (!st.mod_ge) state_nxt = ST_FREE;
			ST_FREE:   if (st.fcnt_end || st.free_hit) state_nxt = ST_RESULT;
			ST_FD_RD:  state_nxt = st.idx_end ? ST_RESULT : ST_FD_CMP;
			ST_FD_CMP: begin
				if (st.opcode == OP_RELEASE)
					state_nxt = (st.live_hit && st.match) ? ST_RESULT : ST_FD_RD;
				else
					state_nxt = (st.live_hit && st.contains) ? ST_RESULT : ST_FD_RD;
			end
			ST_RESULT: if (st.out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_DISPATCH: begin
				case (st.opcode)
					OP_INSERT:  cmd.scan_clr = st.pre_ok;
					OP_RELEASE, OP_FIND_REQ, OP_FIND_LEN: cmd.scan_clr = !st.addr_zero;
					OP_CLEAR:   cmd.do_clear = 1'b1;
					default:    ;
				endcase
			end
			ST_OV_RD: begin
				cmd.mod_init = st.idx_end;
				cmd.rd       = !st.idx_end;
			end
			ST_OV_CMP: cmd.scan_inc = !(st.live_hit && st.overlap);
			ST_MOD: begin
				cmd.mod_sub   = st.mod_ge;
				cmd.free_init = !st.mod_ge;
			end
			ST_FREE: begin
				cmd.do_insert = !st.fcnt_end && st.free_hit;
				cmd.free_step = !st.fcnt_end && !st.free_hit;
			end
			ST_FD_RD: cmd.rd = !st.idx_end;
			ST_FD_CMP: begin
				if (st.opcode == OP_RELEASE) begin
					cmd.do_release = st.live_hit && st.match;
					cmd.scan_inc   = !(st.live_hit && st.match);
				end else begin
					cmd.set_hit  = st.live_hit && st.contains;
					cmd.scan_inc = !(st.live_hit && st.contains);
				end
			end
			ST_RESULT: cmd.res_load = st.out_free;
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: design/art_dp.sv
// Datapath of the allocation range tracker: slot memories, live bits,
// scan counters, totals and the output register. Depends on art_pkg.
module art_dp
	import art_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  in_word_t         in_word,
	input  logic [CNT_W-1:0] slots_in_use,
	input  cmd_t             cmd,
	output status_t          st,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word
);

	logic [63:0] base_mem [SLOT_COUNT];
	logic [63:0] len_mem  [SLOT_COUNT];
	logic [63:0] req_mem  [SLOT_COUNT];

	in_word_t             in_q;
	logic [SLOT_COUNT-1:0] live_q;
	logic [CNT_W-1:0]     hw_q, cnt_q, idx_q, r_q, fcnt_q;
	logic [IDX_W-1:0]     hint_q, fidx_q;
	logic [TOT_W-1:0]     total_q;
	logic [63:0]          rd_base_q, rd_len_q, rd_req_q;
	logic                 ok_q;
	logic [63:0]          res_base_q, res_len_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	logic [CNT_W-1:0] cap, fnext, hnext;
	logic [63:0]      a;

	assign cap   = (slots_in_use > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : slots_in_use;
	assign a     = in_q.address;
	assign fnext = ({1'b0, fidx_q} + 1'b1 == cap) ? '0 : {1'b0, fidx_q} + 1'b1;
	assign hnext = fnext;

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_word;
		if (cmd.rd) begin
			rd_base_q <= base_mem[idx_q[IDX_W-1:0]];
			rd_len_q  <= len_mem[idx_q[IDX_W-1:0]];
			rd_req_q  <= req_mem[idx_q[IDX_W-1:0]];
		end
		if (cmd.do_insert) begin
			base_mem[fidx_q] <= a;
			len_mem[fidx_q]  <= in_q.length;
			req_mem[fidx_q]  <= in_q.requested_length;
		end
		if (cmd.load) begin
			res_base_q <= '0;
			res_len_q  <= '0;
		end else if (cmd.do_release) begin
			res_base_q <= a;
			res_len_q  <= rd_len_q;
		end else if (cmd.set_hit) begin
			res_base_q <= rd_base_q;
			res_len_q  <= (in_q.opcode == OP_FIND_REQ) ? rd_req_q : rd_len_q;
		end
		if (cmd.scan_clr)      idx_q <= '0;
		else if (cmd.scan_inc) idx_q <= idx_q + 1'b1;
		if (cmd.mod_init)      r_q <= {1'b0, hint_q};
		else if (cmd.mod_sub)  r_q <= r_q - cap;
		if (cmd.free_init) begin
			fidx_q <= r_q[IDX_W-1:0];
			fcnt_q <= '0;
		end else if (cmd.free_step) begin
			fidx_q <= fnext[IDX_W-1:0];
			fcnt_q <= fcnt_q + 1'b1;
		end
		if (cmd.res_load) begin
			out_q.success      <= ok_q;
			out_q.base_address <= res_base_q;
			out_q.length_out   <= res_len_q;
			out_q.live_entries <= cnt_q;
			out_q.live_bytes   <= (total_q[TOT_W-1:64] != '0) ? '1 : total_q[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			hw_q        <= '0;
			cnt_q       <= '0;
			hint_q      <= '0;
			total_q     <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) ok_q <= 1'b0;
			if (cmd.do_clear) begin
				live_q  <= '0;
				hw_q    <= '0;
				cnt_q   <= '0;
				hint_q  <= '0;
				total_q <= '0;
				ok_q    <= 1'b1;
			end
			if (cmd.do_insert) begin
				live_q[fidx_q] <= 1'b1;
				cnt_q          <= cnt_q + 1'b1;
				total_q        <= total_q + {7'd0, in_q.length};
				if ({1'b0, fidx_q} >= hw_q) hw_q <= {1'b0, fidx_q} + 1'b1;
				hint_q         <= hnext[IDX_W-1:0];
				ok_q           <= 1'b1;
			end
			if (cmd.do_release) begin
				live_q[idx_q[IDX_W-1:0]] <= 1'b0;
				cnt_q                    <= cnt_q - 1'b1;
				total_q                  <= total_q - {7'd0, rd_len_q};
				hint_q                   <= idx_q[IDX_W-1:0];
				ok_q                     <= 1'b1;
			end
			if (cmd.set_hit) ok_q <= 1'b1;
			if (cmd.res_load)     out_valid_q <= 1'b1;
			else if (!out_stall)  out_valid_q <= 1'b0;
		end
	end

	// insert range checks: zero fields, requested above physical, wrap, full table
	logic pre_ok;
	assign pre_ok = (a != '0) && (in_q.length != '0) && (in_q.requested_length != '0)
		&& (in_q.requested_length <= in_q.length)
		&& ((in_q.length - 64'd1) <= ~a) && (cnt_q < cap);

	always_comb begin
		st           = '0;
		st.opcode    = in_q.opcode;
		st.pre_ok    = pre_ok;
		st.addr_zero = (a == '0);
		st.idx_end   = (idx_q >= hw_q);
		st.live_hit  = live_q[idx_q[IDX_W-1:0]];
		st.overlap   = (a >= rd_base_q) ? ((a - rd_base_q) < rd_len_q)
		                                : ((rd_base_q - a) < in_q.length);
		st.match     = (rd_base_q == a);
		st.contains  = (a >= rd_base_q) && ((a - rd_base_q) < rd_len_q);
		st.mod_ge    = (r_q >= cap);
		st.free_hit  = !live_q[fidx_q];
		st.fcnt_end  = (fcnt_q >= cap);
		st.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// File: design/allocation_range_tracker_unit.sv
// Allocation range tracker: a 64-slot table of live allocations.
// Input channel (in_valid/in_stall/in_word) takes one operation word:
// insert, release, find by requested or physical length, or clear.
// Output channel (out_valid/out_stall/out_word) returns one result word
// per operation with the live slot count and saturated live byte total.
// One operation is in flight at a time; in_stall is high from acceptance
// until its result is loaded into the output register.
// Clear and rejected words go from dispatch straight to the result state.
// Release and find read the slot memories one slot at a time, a read state
// then a compare state, up to the high-water mark. Insert adds the overlap
// scan over the same read and compare states, reduction of the hint modulo
// the capacity by repeated subtraction and the free-slot search (one live
// bit per cycle). Each scan reads one slot at a time through the slot
// memory read port.
// A new word may be accepted while the previous result waits; a stalled
// result holds its word and the next result waits in the sequencer.
// Reset empties the table and sets slots_in_use to 64; no clearing pass.
// APB register 0 (byte address 0): slots_in_use, 7 bits.
module allocation_range_tracker_unit
	import art_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [CNT_W-1:0] slots_in_use_q;
	cmd_t             cmd;
	status_t          st;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_SLOTS_IN_USE) && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slots_in_use_q <= SLOTS_RESET;
		else if (psel && penable && pwrite && reg_sel) slots_in_use_q <= pwdata[CNT_W-1:0];
	end

	assign prdata = reg_sel ? {25'd0, slots_in_use_q} : 32'd0;

	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	art_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_word      (in_word),
		.slots_in_use (slots_in_use_q),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_word     (out_word)
	);

endmodule

// File: test/allocation_range_tracker_unit_test.sv
// Self-checking testbench for allocation_range_tracker_unit: directed table, then random traffic.
// Predicts each result word from its own copy of the slot table; depends on art_pkg and the RTL.
module allocation_range_tracker_unit_test;
	import art_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_word_t           in_word;
	logic               out_valid;
	logic               out_stall;
	out_word_t          out_word;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	allocation_range_tracker_unit dut (.*);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// own copy of the table
	logic [63:0] alloc_base [SLOT_COUNT];
	logic [63:0] alloc_len  [SLOT_COUNT];
	logic [63:0] alloc_req  [SLOT_COUNT];
	bit          alloc_live [SLOT_COUNT];
	int          high_mark;
	int          hint;
	logic [63:0] bytes_lo;
	int          bytes_hi;
	int          live_cnt;
	logic [6:0]  slots_cap;

	out_word_t   results_due[$];
	int          errors;
	bit          idle_on;
	bit          long_hold_req;
	logic [63:0] region [8];

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} row_t;
	row_t rows[$];

	function automatic void empty_table();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			alloc_live[i] = 0;
		end
		high_mark = 0;
		hint      = 0;
		bytes_lo  = '0;
		bytes_hi  = 0;
		live_cnt  = 0;
	endfunction

	// work out the result of one word and update the table copy
	function automatic out_word_t apply_op(in_word_t w);
		out_word_t   r;
		int          cap;
		int          idx;
		bit          ok;
		bit          ov;
		logic [63:0] a;
		logic [64:0] sum;
		r   = '0;
		a   = w.address;
		cap = (slots_cap > SLOT_COUNT) ? SLOT_COUNT : int'(slots_cap);
		case (w.opcode)
			OP_INSERT: begin
				ok = 1;
				if (a == 0 || w.length == 0 || w.requested_length == 0 ||
					w.requested_length > w.length)
					ok = 0;
				else if (w.length - 64'd1 > ~a)
					ok = 0;
				else if (live_cnt >= cap)
					ok = 0;
				for (int i = 0; ok && i < high_mark; i++) begin
					if (alloc_live[i]) begin
						if (a >= alloc_base[i]) ov = (a - alloc_base[i]) < alloc_len[i];
						else ov = (alloc_base[i] - a) < w.length;
						if (ov) ok = 0;
					end
				end
				if (ok) begin
					ok = 0;
					for (int k = 0; !ok && k < cap; k++) begin
						idx = (hint + k) % cap;
						if (!alloc_live[idx]) begin
							alloc_base[idx] = a;
							alloc_len[idx]  = w.length;
							alloc_req[idx]  = w.requested_length;
							alloc_live[idx] = 1;
							live_cnt++;
							sum = {1'b0, bytes_lo} + {1'b0, w.length};
							if (sum[64]) bytes_hi++;
							bytes_lo = sum[63:0];
							if (idx >= high_mark) high_mark = idx + 1;
							hint = (idx + 1) % cap;
							ok = 1;
						end
					end
				end
				r.success = ok;
			end
			OP_RELEASE: begin
				for (int i = 0; a != 0 && !r.success && i < high_mark; i++) begin
					if (alloc_live[i] && alloc_base[i] == a) begin
						r.success      = 1;
						r.base_address = a;
						r.length_out   = alloc_len[i];
						if (bytes_lo < alloc_len[i]) bytes_hi--;
						bytes_lo      = bytes_lo - alloc_len[i];
						alloc_live[i] = 0;
						live_cnt--;
						hint = i;
					end
				end
			end
			OP_FIND_REQ, OP_FIND_LEN: begin
				for (int i = 0; a != 0 && !r.success && i < high_mark; i++) begin
					if (alloc_live[i] && a >= alloc_base[i] &&
						a - alloc_base[i] < alloc_len[i]) begin
						r.success      = 1;
						r.base_address = alloc_base[i];
						r.length_out   = (w.opcode == OP_FIND_REQ) ? alloc_req[i] : alloc_len[i];
					end
				end
			end
			OP_CLEAR: begin
				empty_table();
				r.success = 1;
			end
			default: ;
		endcase
		r.live_entries = live_cnt[6:0];
		r.live_bytes   = (bytes_hi != 0) ? '1 : bytes_lo;
		return r;
	endfunction

	function automatic in_word_t mk(logic [2:0] op, logic [63:0] a, logic [63:0] l,
		logic [63:0] q);
		in_word_t w;
		w.opcode           = op;
		w.address          = a;
		w.length           = l;
		w.requested_length = q;
		return w;
	endfunction

	function automatic void add_row(in_word_t w, bit typed, out_word_t want);
		row_t r;
		r.w     = w;
		r.typed = typed;
		r.want  = want;
		rows.push_back(r);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// base of a live slot if any, else a random probe
	function automatic logic [63:0] pick_live(output int slot);
		int start;
		start = $urandom_range(0, SLOT_COUNT - 1);
		slot  = -1;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (slot < 0 && alloc_live[(start + i) % SLOT_COUNT])
				slot = (start + i) % SLOT_COUNT;
		end
		return (slot >= 0) ? alloc_base[slot] : rand64();
	endfunction

	function automatic in_word_t rand_word();
		in_word_t    w;
		int          sel;
		int          slot;
		int          n;
		logic [63:0] b;
		w   = mk(OP_INSERT, '0, '0, '0);
		sel = $urandom_range(0, 99);
		if (sel < 42) begin
			if ($urandom_range(0, 9) == 0) begin
				w.address          = rand64();
				w.length           = rand64() >> $urandom_range(0, 63);
				w.requested_length = rand64() >> $urandom_range(0, 63);
			end else begin
				w.address = region[$urandom_range(0, 7)] + (64'($urandom_range(0, 255)) << 12);
				n         = $urandom_range(1, 8192);
				w.length  = 64'(n);
				if ($urandom_range(0, 19) == 0)
					w.requested_length = 64'(n) + 64'($urandom_range(0, 3));
				else w.requested_length = 64'($urandom_range(1, n));
			end
		end else if (sel < 66) begin
			w.opcode  = OP_RELEASE;
			b         = pick_live(slot);
			w.address = ($urandom_range(0, 4) != 0) ? b : b + 64'($urandom_range(0, 2));
			w.length  = rand64();
		end else if (sel < 94) begin
			w.opcode  = $urandom_range(0, 1) ? OP_FIND_REQ : OP_FIND_LEN;
			b         = pick_live(slot);
			if (slot >= 0 && $urandom_range(0, 4) != 0)
				w.address = b + (rand64() % alloc_len[slot]);
			else
				w.address = b - 64'($urandom_range(0, 16));
			w.requested_length = rand64();
		end else if (sel < 95) begin
			w.opcode = OP_CLEAR;
		end else begin
			w = mk(3'($urandom_range(5, 7)), rand64(), rand64(), rand64());
			if (sel == 99) w = mk(3'($urandom_range(1, 3)), '0, rand64(), rand64());
		end
		return w;
	endfunction

	// present one word and hold it until taken; valid may drop between words while idle_on is set
	task automatic send(in_word_t w, bit typed, out_word_t want);
		out_word_t predicted;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		predicted = apply_op(w);
		results_due.push_back(typed ? want : predicted);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (results_due.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_slots(logic [6:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_SLOTS_IN_USE);
		pwdata  <= {25'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		slots_cap = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[6:0] !== v) begin
			$display("%0t slots_in_use readback: expected %h actual %h", $time, v, prdata[6:0]);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_word(out_word_t got);
		out_word_t want;
		if (results_due.size() == 0) begin
			$display("%0t unexpected word: expected none actual %h", $time, got);
			errors++;
			return;
		end
		want = results_due.pop_front();
		if (got.success !== want.success) begin
			$display("%0t success: expected %h actual %h", $time, want.success, got.success);
			errors++;
		end
		if (got.base_address !== want.base_address) begin
			$display("%0t base_address: expected %h actual %h", $time,
				want.base_address, got.base_address);
			errors++;
		end
		if (got.length_out !== want.length_out) begin
			$display("%0t length_out: expected %h actual %h", $time,
				want.length_out, got.length_out);
			errors++;
		end
		if (got.live_entries !== want.live_entries) begin
			$display("%0t live_entries: expected %h actual %h", $time,
				want.live_entries, got.live_entries);
			errors++;
		end
		if (got.live_bytes !== want.live_bytes) begin
			$display("%0t live_bytes: expected %h actual %h", $time,
				want.live_bytes, got.live_bytes);
			errors++;
		end
	endtask

	// result side: random stall bursts, plus one long hold on request
	initial begin
		int burst;
		int hold;
		burst     = 0;
		hold      = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) check_word(out_word);
			if (long_hold_req) begin
				long_hold_req = 0;
				hold          = 400;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#16000000;
		$display("FAIL allocation_range_tracker_unit");
		$finish;
	end

	initial begin
		logic [6:0] caps [6];
		out_word_t  none;
		out_word_t  cleared;
		int         sent;
		caps = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64};
		none    = '0;
		cleared = '0;
		cleared.success = 1'b1;
		errors        = 0;
		idle_on       = 1;
		long_hold_req = 0;
		slots_cap     = SLOTS_RESET;
		empty_table();
		for (int i = 0; i < 7; i++) region[i] = rand64();
		region[7] = 64'hFFFF_FFFF_FFF8_0000;	// close to the top, so some ranges wrap

		in_valid = 1'b0;
		in_word  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		arst_n   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(mk(OP_FIND_REQ, 64'h10, 0, 0), 1, none);
		add_row(mk(OP_RELEASE, 64'h10, 0, 0), 1, none);
		add_row(mk(OP_INSERT, 0, 16, 8), 1, none);
		add_row(mk(OP_INSERT, 64'h100, 0, 0), 1, none);
		add_row(mk(OP_INSERT, 64'h100, 16, 0), 1, none);
		add_row(mk(OP_INSERT, 64'h100, 16, 17), 1, none);
		add_row(mk(OP_INSERT, '1, 2, 1), 1, none);
		add_row(mk(OP_INSERT, '1, 1, 1), 0, none);
		add_row(mk(OP_INSERT, 1, 64'h8000_0000_0000_0000, '1 >> 1), 0, none);
		add_row(mk(OP_INSERT, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
			64'h7FFF_FFFF_FFFF_FFFE), 0, none);
		add_row(mk(OP_INSERT, 64'h50, 64'h10, 64'h10), 0, none);
		add_row(mk(OP_FIND_REQ, 64'h8000, 0, 0), 0, none);
		add_row(mk(OP_FIND_LEN, '1, 0, 0), 0, none);
		add_row(mk(OP_FIND_LEN, 0, 0, 0), 0, none);
		add_row(mk(OP_RELEASE, 0, 0, 0), 0, none);
		add_row(mk(OP_RELEASE, 2, 0, 0), 0, none);
		add_row(mk(OP_RELEASE, 1, 0, 0), 0, none);
		add_row(mk(3'd5, '1, '1, '1), 0, none);
		add_row(mk(3'd6, '1, '1, '1), 0, none);
		add_row(mk(3'd7, '1, '1, '1), 0, none);
		add_row(mk(OP_INSERT, 64'h10, 64'h10, 64'h10), 0, none);
		add_row(mk(OP_CLEAR, '1, '1, '1), 1, cleared);
		add_row(mk(OP_FIND_REQ, 64'h10, 0, 0), 1, none);
		foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].want);

		sent = 0;
		foreach (caps[p]) begin
			if (p > 0) begin
				settle();
				write_slots(caps[p]);
			end
			for (int n = 0; n < 170; n++) begin
				if (p == 1 && n == 60) long_hold_req = 1;
				if (p == 3 && n == 60) begin
					in_valid <= 1'b0;
					wait (results_due.size() == 0);
					@(posedge clk);
				end
				if (sent >= 870) idle_on = 0;
				send(rand_word(), 0, none);
				sent++;
			end
		end

		in_valid <= 1'b0;
		wait (results_due.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("PASS allocation_range_tracker_unit");
		end else begin
			$display("FAIL allocation_range_tracker_unit");
		end
		$finish;
	end

endmodule

// File: allocation_range_tracker_unit.f
design/art_pkg.sv
design/art_ctrl.sv
design/art_dp.sv
design/allocation_range_tracker_unit.sv
test/allocation_range_tracker_unit_test.sv
